FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: lbl");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: lbl");
`else
`define CHK_IMPLY(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: src/eul_pkg.sv
// ---------------------------------------------------------------------------
// eul_pkg
// Types, fixed-point constants and helpers for the Euler-to-matrix core.
// ---------------------------------------------------------------------------
`default_nettype none

package eul_pkg;

   // working widths
   localparam int ANG_W  = 36;   // wrapped angle, Q.30 radians
   localparam int CD_W   = 34;   // CORDIC x, y, z
   localparam int TRIG_W = 32;   // sine/cosine after sign fix
   localparam int PROD_W = 33;   // rounded Q.30 products
   localparam int SUM_W  = 35;   // sums of two products
   localparam int ATAN_LEN = 24;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] NEG_PI_Q30  = -36'sd3373259426;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] NEG_HALF_PI_Q30 = -36'sd1686629713;
   localparam logic signed [CD_W-1:0]  GAIN_INV_Q30 = 34'sd652032874;

   localparam logic signed [PROD_W-1:0] SAT_POS = 33'sd16384;
   localparam logic signed [PROD_W-1:0] SAT_NEG = -33'sd16384;

   // floor(atan(2^-i) * 2^30)
   localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
      32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
      32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
      32'd262143,    32'd131071,    32'd65535,     32'd32767,
      32'd16383,     32'd8191,      32'd4095,      32'd2047,
      32'd1023,      32'd511,       32'd255,       32'd127
   };

   typedef struct packed {
      logic signed [15:0] roll_deg;
      logic signed [15:0] pitch_deg;
      logic signed [15:0] yaw_deg;
   } req_type;

   typedef struct packed {
      logic signed [15:0] axis_u_x;
      logic signed [15:0] axis_u_y;
      logic signed [15:0] axis_u_z;
      logic signed [15:0] axis_v_x;
      logic signed [15:0] axis_v_y;
      logic signed [15:0] axis_v_z;
      logic signed [15:0] axis_w_x;
      logic signed [15:0] axis_w_y;
      logic signed [15:0] axis_w_z;
   } rsp_type;

   // one CORDIC lane word passed from cell to cell
   typedef struct packed {
      logic signed [CD_W-1:0] x;
      logic signed [CD_W-1:0] y;
      logic signed [CD_W-1:0] z;
      logic                   neg;
   } cordic_type;

   // Q.30 times Q.30, round half up back to Q.30
   function automatic logic signed [PROD_W-1:0] mul30(
      input logic signed [PROD_W-1:0] a,
      input logic signed [PROD_W-1:0] b);
      logic signed [2*PROD_W-1:0] p;
      p = (2*PROD_W)'(a) * (2*PROD_W)'(b);
      p = p + (2*PROD_W)'(64'sd536870912);
      return p[PROD_W+29:30];
   endfunction

   // Q.30 to Q1.14 with round half up and saturation to +-1.0
   function automatic logic signed [15:0] to_q14(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v + SUM_W'(32768)) >>> 16;
      if (r > SUM_W'(SAT_POS)) begin
         r = SUM_W'(SAT_POS);
      end else if (r < SUM_W'(SAT_NEG)) begin
         r = SUM_W'(SAT_NEG);
      end
      return r[15:0];
   endfunction

endpackage

`default_nettype wire

FILE: src/eul_angle_prep.sv
// ---------------------------------------------------------------------------
// eul_angle_prep
// Degrees to Q.30 radians, wrap to [-pi, pi], fold to [-pi/2, pi/2].
// Three register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module eul_angle_prep
   import eul_pkg::*;
#(
   parameter int COEF_WIDTH = 16
) (
   input  wire logic              clock,
   input  wire logic signed [15:0] deg,
   output cordic_type             lane
);

   localparam int PW  = 17 + COEF_WIDTH;
   localparam int SH  = COEF_WIDTH - 24;
   localparam int RSH = (SH > 0) ? SH : 0;
   localparam int LSH = (SH < 0) ? -SH : 0;
   localparam int WW  = PW + 26;
   localparam longint unsigned SCALE_L = ((64'd1745 << COEF_WIDTH) + 64'd50000) / 64'd100000;
   localparam logic [COEF_WIDTH-1:0] SCALE = COEF_WIDTH'(SCALE_L);
   localparam logic signed [WW-1:0] RND =
      (RSH > 0) ? (WW'(1) << ((RSH > 0) ? RSH - 1 : 0)) : '0;

   logic signed [PW-1:0]    prod_in, prod_ff;
   logic signed [WW-1:0]    wide;
   logic signed [ANG_W-1:0] th, th_in, th_ff;
   cordic_type              lane_in, lane_ff;

   // scale multiply
   always_comb begin
      prod_in = PW'(deg) * $signed({1'b0, SCALE});
   end

   // bring to Q.30 and wrap once
   always_comb begin
      wide = ((WW'(prod_ff) + RND) >>> RSH) <<< LSH;
      th   = wide[ANG_W-1:0];
      if (th > PI_Q30) begin
         th_in = th - TWO_PI_Q30;
      end else if (th < NEG_PI_Q30) begin
         th_in = th + TWO_PI_Q30;
      end else begin
         th_in = th;
      end
   end

   // fold into the CORDIC range; a fold by pi flips both outputs
   always_comb begin
      lane_in.x   = GAIN_INV_Q30;
      lane_in.y   = '0;
      lane_in.neg = 1'b0;
      lane_in.z   = CD_W'(th_ff);
      if (th_ff > HALF_PI_Q30) begin
         lane_in.z   = CD_W'(th_ff - PI_Q30);
         lane_in.neg = 1'b1;
      end else if (th_ff < NEG_HALF_PI_Q30) begin
         lane_in.z   = CD_W'(th_ff + PI_Q30);
         lane_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      th_ff   <= th_in;
      lane_ff <= lane_in;
   end

   assign lane = lane_ff;

endmodule

`default_nettype wire

FILE: src/eul_cordic_cell.sv
// ---------------------------------------------------------------------------
// eul_cordic_cell
// One rotation-mode CORDIC step with its output register.
// ---------------------------------------------------------------------------
`default_nettype none

module eul_cordic_cell
   import eul_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic       clock,
   input  wire cordic_type lane_i,
   output cordic_type      lane_o
);

   localparam logic signed [CD_W-1:0] ATAN = CD_W'(ATAN_Q30[STEP]);

   logic signed [CD_W-1:0] dx, dy;
   cordic_type             lane_in, lane_ff;

   // rotate toward z = 0
   always_comb begin
      dx = lane_i.y >>> STEP;
      dy = lane_i.x >>> STEP;
      lane_in.neg = lane_i.neg;
      if (!lane_i.z[CD_W-1]) begin
         lane_in.x = lane_i.x - dx;
         lane_in.y = lane_i.y + dy;
         lane_in.z = lane_i.z - ATAN;
      end else begin
         lane_in.x = lane_i.x + dx;
         lane_in.y = lane_i.y - dy;
         lane_in.z = lane_i.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign lane_o = lane_ff;

endmodule

`default_nettype wire

FILE: src/eul_matrix.sv
// ---------------------------------------------------------------------------
// eul_matrix
// Sign fix, pairwise and triple products, round and saturate to Q1.14.
// Four register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module eul_matrix
   import eul_pkg::*;
(
   input  wire logic       clock,
   input  wire cordic_type roll_i,
   input  wire cordic_type pitch_i,
   input  wire cordic_type yaw_i,
   output rsp_type         word_o
);

   logic signed [TRIG_W-1:0] sr_ff, cr_ff, sp_ff, cp_ff, sy_ff, cy_ff;
   logic signed [PROD_W-1:0] srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, nsp_ff, srcp_ff, crcp_ff;
   logic signed [PROD_W-1:0] crsy_ff, crcy_ff, srsy_ff, srcy_ff, sy1_ff, cy1_ff;
   logic signed [PROD_W-1:0] a_ff [4];   // srsp*cy, srsp*sy, crsp*cy, crsp*sy
   logic signed [PROD_W-1:0] crsy2_ff, crcy2_ff, srsy2_ff, srcy2_ff;
   logic signed [PROD_W-1:0] cpcy2_ff, cpsy2_ff, nsp2_ff, srcp2_ff, crcp2_ff;
   rsp_type                  word_in, word_ff;

   // undo the fold sign
   always_ff @(posedge clock) begin
      sr_ff <= TRIG_W'(roll_i.neg  ? -roll_i.y  : roll_i.y);
      cr_ff <= TRIG_W'(roll_i.neg  ? -roll_i.x  : roll_i.x);
      sp_ff <= TRIG_W'(pitch_i.neg ? -pitch_i.y : pitch_i.y);
      cp_ff <= TRIG_W'(pitch_i.neg ? -pitch_i.x : pitch_i.x);
      sy_ff <= TRIG_W'(yaw_i.neg   ? -yaw_i.y   : yaw_i.y);
      cy_ff <= TRIG_W'(yaw_i.neg   ? -yaw_i.x   : yaw_i.x);
   end

   // pairwise products
   always_ff @(posedge clock) begin
      srsp_ff <= mul30(PROD_W'(sr_ff), PROD_W'(sp_ff));
      crsp_ff <= mul30(PROD_W'(cr_ff), PROD_W'(sp_ff));
      cpcy_ff <= mul30(PROD_W'(cp_ff), PROD_W'(cy_ff));
      cpsy_ff <= mul30(PROD_W'(cp_ff), PROD_W'(sy_ff));
      srcp_ff <= mul30(PROD_W'(sr_ff), PROD_W'(cp_ff));
      crcp_ff <= mul30(PROD_W'(cr_ff), PROD_W'(cp_ff));
      crsy_ff <= mul30(PROD_W'(cr_ff), PROD_W'(sy_ff));
      crcy_ff <= mul30(PROD_W'(cr_ff), PROD_W'(cy_ff));
      srsy_ff <= mul30(PROD_W'(sr_ff), PROD_W'(sy_ff));
      srcy_ff <= mul30(PROD_W'(sr_ff), PROD_W'(cy_ff));
      nsp_ff  <= -PROD_W'(sp_ff);
      sy1_ff  <= PROD_W'(sy_ff);
      cy1_ff  <= PROD_W'(cy_ff);
   end

   // triple products, carry the rest along
   always_ff @(posedge clock) begin
      a_ff[0]  <= mul30(srsp_ff, cy1_ff);
      a_ff[1]  <= mul30(srsp_ff, sy1_ff);
      a_ff[2]  <= mul30(crsp_ff, cy1_ff);
      a_ff[3]  <= mul30(crsp_ff, sy1_ff);
      crsy2_ff <= crsy_ff;
      crcy2_ff <= crcy_ff;
      srsy2_ff <= srsy_ff;
      srcy2_ff <= srcy_ff;
      cpcy2_ff <= cpcy_ff;
      cpsy2_ff <= cpsy_ff;
      nsp2_ff  <= nsp_ff;
      srcp2_ff <= srcp_ff;
      crcp2_ff <= crcp_ff;
   end

   // sums and output rounding
   always_comb begin
      word_in.axis_u_x = to_q14(SUM_W'(cpcy2_ff));
      word_in.axis_u_y = to_q14(SUM_W'(cpsy2_ff));
      word_in.axis_u_z = to_q14(SUM_W'(nsp2_ff));
      word_in.axis_v_x = to_q14(SUM_W'(a_ff[0]) - SUM_W'(crsy2_ff));
      word_in.axis_v_y = to_q14(SUM_W'(a_ff[1]) + SUM_W'(crcy2_ff));
      word_in.axis_v_z = to_q14(SUM_W'(srcp2_ff));
      word_in.axis_w_x = to_q14(SUM_W'(a_ff[2]) + SUM_W'(srsy2_ff));
      word_in.axis_w_y = to_q14(SUM_W'(a_ff[3]) - SUM_W'(srcy2_ff));
      word_in.axis_w_z = to_q14(SUM_W'(crcp2_ff));
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_o = word_ff;

endmodule

`default_nettype wire

FILE: src/euler_to_rotation_matrix_core.sv
// ---------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// Roll/pitch/yaw in Q10.6 degrees to a 3x3 rotation matrix in Q1.14.
// ---------------------------------------------------------------------------
// Fully pipelined: one angle triple is taken every clock (busy is low except
// during reset) and its matrix appears on rsp_data with rsp_valid high for
// one cycle. The path runs through three angle-prep stages, one CORDIC cell
// per iteration and four product/rounding stages. The result cannot be held
// off; capture it on the strobe.
`default_nettype none
`include "assert_macros.svh"

module euler_to_rotation_matrix_core
   import eul_pkg::*;
#(
   parameter int COEF_WIDTH        = 16,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int LAT = CORDIC_ITERATIONS + 7;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   logic               fire;
   logic [LAT-1:0]     valid_ff, valid_in;
   logic signed [15:0] ang [3];
   cordic_type         chain [3][CORDIC_ITERATIONS+1];
   logic               uz_in_range, vy_in_range;

   assign busy = reset;
   assign fire = start && !busy;

   assign ang[0] = req_data.roll_deg;
   assign ang[1] = req_data.pitch_deg;
   assign ang[2] = req_data.yaw_deg;

   // one prep unit and one CORDIC row per angle
   for (genvar a = 0; a < 3; a++) begin : g_axis
      eul_angle_prep #(.COEF_WIDTH(COEF_WIDTH)) u_prep (
         .clock(clock), .deg(ang[a]), .lane(chain[a][0]));
      for (genvar s = 0; s < CORDIC_ITERATIONS; s++) begin : g_cell
         eul_cordic_cell #(.STEP(s)) u_cell (
            .clock(clock), .lane_i(chain[a][s]), .lane_o(chain[a][s+1]));
      end
   end

   eul_matrix u_matrix (
      .clock  (clock),
      .roll_i (chain[0][CORDIC_ITERATIONS]),
      .pitch_i(chain[1][CORDIC_ITERATIONS]),
      .yaw_i  (chain[2][CORDIC_ITERATIONS]),
      .word_o (rsp_data)
   );

   // valid tracking alongside the data path
   assign valid_in = {valid_ff[LAT-2:0], fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LAT-1];

   // saturation window of the output entries
   assign uz_in_range = (rsp_data.axis_u_z <= ONE_Q14) && (rsp_data.axis_u_z >= -ONE_Q14);
   assign vy_in_range = (rsp_data.axis_v_y <= ONE_Q14) && (rsp_data.axis_v_y >= -ONE_Q14);

   `CHK_IMPLY(a_latency, clock, reset, 1'b1, rsp_valid == $past(fire, LAT))
   `CHK_NEXT(a_enter, clock, reset, fire, valid_ff[0])
   `CHK_IMPLY(a_uz_sat, clock, reset, rsp_valid, uz_in_range)
   `CHK_IMPLY(a_vy_sat, clock, reset, rsp_valid, vy_in_range)

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Euler-angle to rotation-matrix core.
// ---------------------------------------------------------------------------
// Angle triples go in through the start/busy command port. Each one accepted
// gets its matrix predicted with a bit-exact fixed-point model: degree
// scaling, wrap and fold, CORDIC and rounded products. The strobed results
// are compared, entry by entry and in order, against that prediction.
// Directed corners come first, then random triples under several idle mixes.
`default_nettype none

module tb_top;
   import eul_pkg::*;

   localparam int      ITERS      = 16;
   localparam int      PIPE_DEPTH = ITERS + 7;
   localparam longint  DEG_COEF   = 1144;   // round(0.01745 * 2^16)
   localparam longint  PI_FX      = 64'sd3373259426;
   localparam longint  TWO_PI_FX  = 64'sd6746518852;
   localparam longint  HALF_PI_FX = 64'sd1686629713;
   localparam longint  GAIN_FX    = 64'sd652032874;
   localparam int      REPORT_MAX = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type matrix_q[$];
   int      mismatch_cnt = 0;
   int      words_sent   = 0;
   int      words_checked = 0;
   int      idle_pct     = 0;

   euler_to_rotation_matrix_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // sine and cosine of one Q10.6 degree angle, Q.30
   function automatic void angle_sin_cos(input logic signed [15:0] deg,
                                         output longint s, output longint c);
      longint th, x, y, dx, dy;
      bit     flip;
      th = longint'(deg) * DEG_COEF;
      th = th <<< 8;   // Q.22 product up to Q.30
      flip = 1'b0;
      x = GAIN_FX;
      y = 0;
      while (th > PI_FX) th -= TWO_PI_FX;
      while (th < -PI_FX) th += TWO_PI_FX;
      if (th > HALF_PI_FX) begin
         th -= PI_FX;
         flip = 1'b1;
      end else if (th < -HALF_PI_FX) begin
         th += PI_FX;
         flip = 1'b1;
      end
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (th >= 0) begin
            x -= dx;
            y += dy;
            th -= longint'(ATAN_Q30[i]);
         end else begin
            x += dx;
            y -= dy;
            th += longint'(ATAN_Q30[i]);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic signed [15:0] fx_to_q14(input longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic rsp_type rotation_matrix(input req_type a);
      longint sr, cr, sp, cp, sy, cy, srsp, crsp;
      rsp_type m;
      angle_sin_cos(a.roll_deg, sr, cr);
      angle_sin_cos(a.pitch_deg, sp, cp);
      angle_sin_cos(a.yaw_deg, sy, cy);
      srsp = fx_mul(sr, sp);
      crsp = fx_mul(cr, sp);
      m.axis_u_x = fx_to_q14(fx_mul(cp, cy));
      m.axis_u_y = fx_to_q14(fx_mul(cp, sy));
      m.axis_u_z = fx_to_q14(-sp);
      m.axis_v_x = fx_to_q14(fx_mul(srsp, cy) - fx_mul(cr, sy));
      m.axis_v_y = fx_to_q14(fx_mul(srsp, sy) + fx_mul(cr, cy));
      m.axis_v_z = fx_to_q14(fx_mul(sr, cp));
      m.axis_w_x = fx_to_q14(fx_mul(crsp, cy) + fx_mul(sr, sy));
      m.axis_w_y = fx_to_q14(fx_mul(crsp, sy) - fx_mul(sr, cy));
      m.axis_w_z = fx_to_q14(fx_mul(cr, cp));
      return m;
   endfunction

   // result checker: every strobe against the oldest prediction
   always @(posedge clock) begin
      rsp_type           want;
      logic signed [15:0] got_e, want_e;
      string             names [9];
      names = '{"u_x", "u_y", "u_z", "v_x", "v_y", "v_z", "w_x", "w_y", "w_z"};
      if (!reset && rsp_valid) begin
         if (matrix_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
               $display("unexpected result word %h", rsp_data);
         end else begin
            want = matrix_q.pop_front();
            words_checked++;
            for (int k = 0; k < 9; k++) begin
               want_e = want[(8-k)*16 +: 16];
               got_e  = rsp_data[(8-k)*16 +: 16];
               if (got_e !== want_e) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= REPORT_MAX)
                     $display("mismatch word %0d axis_%s: expected %0d got %0d",
                              words_checked, names[k], want_e, got_e);
               end
            end
         end
      end
   end

   // one angle word through the command port, with optional idle gap
   task automatic send_word(input req_type a);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = a;
      do @(posedge clock); while (busy);
      matrix_q.push_back(rotation_matrix(a));
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_angles(input int r, input int p, input int y);
      req_type a;
      a.roll_deg  = 16'(r);
      a.pitch_deg = 16'(p);
      a.yaw_deg   = 16'(y);
      send_word(a);
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (matrix_q.size() != 0) @(negedge clock);
   endtask

   // corners: zero, extremes, right angles, half turn, wrap points
   task automatic test_directed();
      idle_pct = 0;
      send_angles(0, 0, 0);
      send_angles(32767, 32767, 32767);
      send_angles(-32768, -32768, -32768);
      send_angles(32767, -32768, 0);
      send_angles(5760, 0, 0);
      send_angles(0, 5760, 0);
      send_angles(0, 0, 5760);
      send_angles(-5760, -5760, -5760);
      send_angles(11520, 11520, 11520);
      send_angles(-11520, 0, 11520);
      send_angles(2880, 2880, 2880);
      send_angles(-2880, 5760, -2880);
      send_angles(23040, -23040, 17280);
      send_angles(5761, 5759, -5761);
      send_angles(11521, -11521, 11519);
      send_angles(1, -1, 1);
      send_angles(16'h5555, 16'hAAAA, 16'h5555);
      send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
      send_angles(3840, 1920, 960);
      send_angles(-17280, 17280, -1);
      wait_drained();
   endtask

   // random triples: mostly full range, some inside one turn
   task automatic test_random(input int n, input int pct);
      req_type a;
      idle_pct = pct;
      repeat (n) begin
         if ($urandom_range(3) == 0) begin
            a.roll_deg  = 16'($signed($urandom_range(23040)) - 11520);
            a.pitch_deg = 16'($signed($urandom_range(23040)) - 11520);
            a.yaw_deg   = 16'($signed($urandom_range(23040)) - 11520);
         end else begin
            a = req_type'({$urandom, $urandom});
         end
         send_word(a);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_random(600, 0);
      test_random(500, 65);
      wait_drained();      // sender holds off until the pipe is empty
      test_random(500, 27);
      test_random(400, 0);
      wait_drained();
      repeat (PIPE_DEPTH + 10) @(negedge clock);
      $display("sent %0d angle words, checked %0d matrices, %0d mismatches",
               words_sent, words_checked, mismatch_cnt);
      $display("covered corners, wrap and fold points, idle mixes 0/65/27 pct");
      if (mismatch_cnt == 0 && matrix_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
